@@ src/saddle_aware_span_interpolation_assert.svh @@
// ----------------------------------------------------------------------------
// saddle_aware_span_interpolation assertion macros
// Concurrent assertion wrappers for the span interpolation block; they
// expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef SADDLE_AWARE_SPAN_INTERPOLATION_ASSERT_SVH
`define SADDLE_AWARE_SPAN_INTERPOLATION_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SASI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sasi assertion failed");
// next-cycle implication
`define SASI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sasi assertion failed");
`else
`define SASI_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SASI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ src/sasi_pkg.sv @@
// ----------------------------------------------------------------------------
// sasi_pkg
// Shared types and constants of the span interpolation block.
// ----------------------------------------------------------------------------
`default_nettype none

package sasi_pkg;

    // field widths, height limit and queue depth
    localparam int PIX_W        = 8;
    localparam int GRID_W       = 12;
    localparam int ROW_W        = 10;
    localparam int HGT_W        = 11;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 11;
    localparam int QUEUE_DEPTH  = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    // saddle link codes
    localparam logic [1:0] DIAG_NONE = 2'd0;
    localparam logic [1:0] DIAG_MAIN = 2'd1;
    localparam logic [1:0] DIAG_ANTI = 2'd2;

    // face sequence of one pixel
    typedef enum logic [3:0] {
        FS_ZERO,
        FS_HORZ,
        FS_HORZ_END,
        FS_VERT,
        FS_PIXEL,
        FS_PIXEL_END,
        FS_BOT_VERT,
        FS_BOT_PIXEL,
        FS_BOT_END
    } t_face_step;

    // classified pixel, as queued between front and back
    typedef struct packed {
        logic [PIX_W-1:0]  pix;
        logic [PIX_W-1:0]  z_lo;
        logic [PIX_W-1:0]  z_hi;
        logic [1:0]        z_code;
        logic [PIX_W-1:0]  hz_lo;
        logic [PIX_W-1:0]  hz_hi;
        logic [PIX_W-1:0]  vt_lo;
        logic [PIX_W-1:0]  vt_hi;
        logic [GRID_W-1:0] gr0;
        logic [GRID_W-1:0] gc0;
        logic [GRID_W-1:0] gw;
        logic [GRID_W-1:0] gh;
        logic              last_c;
        logic              last_r;
    } t_entry;

    // queue status seen by the front and back ends
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

`default_nettype wire

@@ src/sasi_front.sv @@
// ----------------------------------------------------------------------------
// sasi_front
// Accepts pixels, keeps the line store and counters, and classifies each
// pixel into the intervals of its faces.
// ----------------------------------------------------------------------------
`default_nettype none

module sasi_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_pixel_valid,
    output logic                             o_pixel_ready,
    input  logic [sasi_pkg::PIX_W-1:0]       i_pixel,
    input  logic                             i_cfg_wr_en,
    input  logic [sasi_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sasi_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  sasi_pkg::t_queue_stat            i_queue_stat,
    output logic                             o_push,
    output sasi_pkg::t_entry                 o_entry
);

    localparam int PB = (PIXEL_BITS < sasi_pkg::PIX_W) ? PIXEL_BITS : sasi_pkg::PIX_W;
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [WW-1:0]                 r_width;
    logic [sasi_pkg::HGT_W-1:0]    r_height;
    logic [CW-1:0]                 r_col;
    logic [sasi_pkg::ROW_W-1:0]    r_row;
    logic [PB-1:0]                 r_left;
    logic [PB-1:0]                 r_up_left;
    logic [PB-1:0]                 r_rd;
    logic [PB-1:0]                 mem_line [MAX_WIDTH];

    logic                          r_s1_valid;
    logic [PB-1:0]                 r_s1_pix;
    logic [PB-1:0]                 r_s1_left;
    logic                          r_s1_row0;
    logic                          r_s1_col0;
    logic                          r_s1_last_c;
    logic                          r_s1_last_r;
    logic [sasi_pkg::GRID_W-1:0]   r_s1_gr;
    logic [sasi_pkg::GRID_W-1:0]   r_s1_gc;
    logic [sasi_pkg::GRID_W-1:0]   r_s1_gw;
    logic [sasi_pkg::GRID_W-1:0]   r_s1_gh;

    logic [PB-1:0]                 pix_in;
    logic                          accept;
    logic                          cfg_hit;
    logic                          last_c;
    logic                          last_r;
    logic [WW-1:0]                 cfg_width;
    logic [sasi_pkg::HGT_W-1:0]    cfg_height;

    logic [PB-1:0] mlo, mhi, alo, ahi, uplo, uphi, lflo, lfhi;
    logic [PB-1:0] z_lo, z_hi, hz_lo, hz_hi, vt_lo, vt_hi;
    logic [1:0]    z_code;

    function automatic logic [PB-1:0] f_min(input logic [PB-1:0] a, input logic [PB-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [PB-1:0] f_max(input logic [PB-1:0] a, input logic [PB-1:0] b);
        return (a > b) ? a : b;
    endfunction

    // handshake and frame position
    assign pix_in        = i_pixel[PB-1:0];
    assign o_push        = r_s1_valid && !i_queue_stat.full;
    assign o_pixel_ready = !r_s1_valid || !i_queue_stat.full;
    assign accept        = i_pixel_valid && o_pixel_ready;
    assign cfg_hit       = i_cfg_wr_en && ((i_cfg_index == sasi_pkg::CFG_IMAGE_WIDTH) ||
                                           (i_cfg_index == sasi_pkg::CFG_IMAGE_HEIGHT));
    assign last_c        = (32'(r_col) + 32'd1) >= 32'(r_width);
    assign last_r        = (32'(r_row) + 32'd1) >= 32'(r_height);

    // clamp written sizes to the supported range
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_width = WW'(1);
        end else if (32'(i_cfg_data) > 32'(MAX_WIDTH)) begin
            cfg_width = WW'(MAX_WIDTH);
        end else begin
            cfg_width = WW'(i_cfg_data);
        end
        if (i_cfg_data == '0) begin
            cfg_height = sasi_pkg::HGT_W'(1);
        end else if (32'(i_cfg_data) > 32'(sasi_pkg::HEIGHT_LIMIT)) begin
            cfg_height = sasi_pkg::HGT_W'(sasi_pkg::HEIGHT_LIMIT);
        end else begin
            cfg_height = i_cfg_data;
        end
    end

    // config, counters, neighbor pixels and stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WW'(1);
            r_height   <= sasi_pkg::HGT_W'(1);
            r_col      <= '0;
            r_row      <= '0;
            r_left     <= '0;
            r_up_left  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (cfg_hit) begin
                if (i_cfg_index == sasi_pkg::CFG_IMAGE_WIDTH) begin
                    r_width <= cfg_width;
                end else begin
                    r_height <= cfg_height;
                end
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                if (last_c) begin
                    r_col <= '0;
                    r_row <= last_r ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (accept) begin
                r_left     <= pix_in;
                r_s1_valid <= 1'b1;
            end else if (o_push) begin
                r_s1_valid <= 1'b0;
            end
            if (o_push) begin
                r_up_left <= r_rd;
            end
        end
    end

    // line store: read the pixel above, then overwrite it
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd           <= mem_line[r_col];
            mem_line[r_col] <= pix_in;
        end
    end

    // stage one payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix    <= pix_in;
            r_s1_left   <= r_left;
            r_s1_row0   <= (r_row == '0);
            r_s1_col0   <= (r_col == '0);
            r_s1_last_c <= last_c;
            r_s1_last_r <= last_r;
            r_s1_gr     <= sasi_pkg::GRID_W'({r_row, 1'b0});
            r_s1_gc     <= sasi_pkg::GRID_W'({r_col, 1'b0});
            r_s1_gw     <= sasi_pkg::GRID_W'({r_width, 1'b0});
            r_s1_gh     <= sasi_pkg::GRID_W'({r_height, 1'b0});
        end
    end

    // pairs and diagonals
    always_comb begin
        mlo  = f_min(r_up_left, r_s1_pix);
        mhi  = f_max(r_up_left, r_s1_pix);
        alo  = f_min(r_rd, r_s1_left);
        ahi  = f_max(r_rd, r_s1_left);
        uplo = f_min(r_rd, r_s1_pix);
        uphi = f_max(r_rd, r_s1_pix);
        lflo = f_min(r_s1_left, r_s1_pix);
        lfhi = f_max(r_s1_left, r_s1_pix);
    end

    // corner face with saddle resolution
    always_comb begin
        z_lo   = r_s1_pix;
        z_hi   = r_s1_pix;
        z_code = sasi_pkg::DIAG_NONE;
        if (r_s1_row0 && r_s1_col0) begin
            z_lo = r_s1_pix;
        end else if (r_s1_row0) begin
            z_lo = lflo;
            z_hi = lfhi;
        end else if (r_s1_col0) begin
            z_lo = uplo;
            z_hi = uphi;
        end else if (ahi > mlo) begin
            z_lo   = mlo;
            z_hi   = mhi;
            z_code = sasi_pkg::DIAG_MAIN;
        end else if (mhi > alo) begin
            z_lo   = alo;
            z_hi   = ahi;
            z_code = sasi_pkg::DIAG_ANTI;
        end
        hz_lo = r_s1_row0 ? r_s1_pix : uplo;
        hz_hi = r_s1_row0 ? r_s1_pix : uphi;
        vt_lo = r_s1_col0 ? r_s1_pix : lflo;
        vt_hi = r_s1_col0 ? r_s1_pix : lfhi;
    end

    // queue entry
    always_comb begin
        o_entry.pix    = sasi_pkg::PIX_W'(r_s1_pix);
        o_entry.z_lo   = sasi_pkg::PIX_W'(z_lo);
        o_entry.z_hi   = sasi_pkg::PIX_W'(z_hi);
        o_entry.z_code = z_code;
        o_entry.hz_lo  = sasi_pkg::PIX_W'(hz_lo);
        o_entry.hz_hi  = sasi_pkg::PIX_W'(hz_hi);
        o_entry.vt_lo  = sasi_pkg::PIX_W'(vt_lo);
        o_entry.vt_hi  = sasi_pkg::PIX_W'(vt_hi);
        o_entry.gr0    = r_s1_gr;
        o_entry.gc0    = r_s1_gc;
        o_entry.gw     = r_s1_gw;
        o_entry.gh     = r_s1_gh;
        o_entry.last_c = r_s1_last_c;
        o_entry.last_r = r_s1_last_r;
    end

endmodule

`default_nettype wire

@@ src/sasi_queue.sv @@
// ----------------------------------------------------------------------------
// sasi_queue
// Short queue of classified pixels between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sasi_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  sasi_pkg::t_entry      i_entry,
    input  logic                  i_pop,
    output sasi_pkg::t_entry      o_entry,
    output sasi_pkg::t_queue_stat o_stat
);

    localparam int DEPTH = sasi_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    sasi_pkg::t_entry r_slot [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;

    // status and head entry
    assign o_stat.full  = (r_count == (AW+1)'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_entry      = r_slot[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

@@ src/sasi_back.sv @@
// ----------------------------------------------------------------------------
// sasi_back
// Walks the faces of the pixel at the queue head, one face per cycle while
// the receiver takes them, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sasi_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sasi_pkg::t_entry                  i_entry,
    input  sasi_pkg::t_queue_stat             i_queue_stat,
    output logic                              o_pop,
    input  logic                              i_face_ready,
    output logic                              o_face_valid,
    output logic [sasi_pkg::GRID_W-1:0]       o_grid_row,
    output logic [sasi_pkg::GRID_W-1:0]       o_grid_col,
    output logic [sasi_pkg::PIX_W-1:0]        o_low_value,
    output logic [sasi_pkg::PIX_W-1:0]        o_high_value,
    output logic [1:0]                        o_diag_code,
    output logic                              o_last_of_run
);

    sasi_pkg::t_face_step        r_step;
    sasi_pkg::t_face_step        n_step;
    sasi_pkg::t_face_step        step_after;
    logic                        r_out_valid;
    logic                        load;
    logic                        f_last;
    logic [sasi_pkg::GRID_W-1:0] f_row;
    logic [sasi_pkg::GRID_W-1:0] f_col;
    logic [sasi_pkg::GRID_W-1:0] row_odd;
    logic [sasi_pkg::GRID_W-1:0] col_odd;
    logic [sasi_pkg::PIX_W-1:0]  f_lo;
    logic [sasi_pkg::PIX_W-1:0]  f_hi;
    logic [1:0]                  f_code;

    // output register takes a face whenever the queue holds an entry and the register is free or being drained
    assign load         = !i_queue_stat.empty && (!r_out_valid || i_face_ready);
    assign o_pop        = load && f_last;
    assign o_face_valid = r_out_valid;
    assign row_odd      = i_entry.gr0 | sasi_pkg::GRID_W'(1);
    assign col_odd      = i_entry.gc0 | sasi_pkg::GRID_W'(1);

    // step register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= sasi_pkg::FS_ZERO;
        end else begin
            r_step <= n_step;
        end
    end

    // face of the current step and the step after it
    always_comb begin
        step_after = sasi_pkg::FS_ZERO;
        f_last     = 1'b0;
        f_row      = i_entry.gr0;
        f_col      = i_entry.gc0;
        f_lo       = i_entry.pix;
        f_hi       = i_entry.pix;
        f_code     = sasi_pkg::DIAG_NONE;
        case (r_step)
            sasi_pkg::FS_ZERO: begin
                f_lo       = i_entry.z_lo;
                f_hi       = i_entry.z_hi;
                f_code     = i_entry.z_code;
                step_after = sasi_pkg::FS_HORZ;
            end
            sasi_pkg::FS_HORZ: begin
                f_col      = col_odd;
                f_lo       = i_entry.hz_lo;
                f_hi       = i_entry.hz_hi;
                step_after = i_entry.last_c ? sasi_pkg::FS_HORZ_END : sasi_pkg::FS_VERT;
            end
            sasi_pkg::FS_HORZ_END: begin
                f_col      = i_entry.gw;
                f_lo       = i_entry.hz_lo;
                f_hi       = i_entry.hz_hi;
                step_after = sasi_pkg::FS_VERT;
            end
            sasi_pkg::FS_VERT: begin
                f_row      = row_odd;
                f_lo       = i_entry.vt_lo;
                f_hi       = i_entry.vt_hi;
                step_after = sasi_pkg::FS_PIXEL;
            end
            sasi_pkg::FS_PIXEL: begin
                f_row = row_odd;
                f_col = col_odd;
                if (i_entry.last_c) begin
                    step_after = sasi_pkg::FS_PIXEL_END;
                end else if (i_entry.last_r) begin
                    step_after = sasi_pkg::FS_BOT_VERT;
                end else begin
                    f_last = 1'b1;
                end
            end
            sasi_pkg::FS_PIXEL_END: begin
                f_row = row_odd;
                f_col = i_entry.gw;
                if (i_entry.last_r) begin
                    step_after = sasi_pkg::FS_BOT_VERT;
                end else begin
                    f_last = 1'b1;
                end
            end
            sasi_pkg::FS_BOT_VERT: begin
                f_row      = i_entry.gh;
                f_lo       = i_entry.vt_lo;
                f_hi       = i_entry.vt_hi;
                step_after = sasi_pkg::FS_BOT_PIXEL;
            end
            sasi_pkg::FS_BOT_PIXEL: begin
                f_row = i_entry.gh;
                f_col = col_odd;
                if (i_entry.last_c) begin
                    step_after = sasi_pkg::FS_BOT_END;
                end else begin
                    f_last = 1'b1;
                end
            end
            sasi_pkg::FS_BOT_END: begin
                f_row  = i_entry.gh;
                f_col  = i_entry.gw;
                f_last = 1'b1;
            end
            default: begin
                f_last = 1'b1;
            end
        endcase
        if (!load) begin
            n_step = r_step;
        end else if (f_last) begin
            n_step = sasi_pkg::FS_ZERO;
        end else begin
            n_step = step_after;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_face_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            o_grid_row    <= f_row;
            o_grid_col    <= f_col;
            o_low_value   <= f_lo;
            o_high_value  <= f_hi;
            o_diag_code   <= f_code;
            o_last_of_run <= f_last;
        end
    end

endmodule

`default_nettype wire

@@ src/saddle_aware_span_interpolation.sv @@
// ----------------------------------------------------------------------------
// saddle_aware_span_interpolation
// Streams raster-order pixels into interval-valued faces of the doubled
// grid, resolving interior saddles by a diagonal link code.
// ----------------------------------------------------------------------------
// Usage:
//   i_pixel_valid/o_pixel_ready carries one pixel per transaction, raster
//   order. o_face_valid/i_face_ready carries one face per transaction: grid
//   position, [low, high] interval, diagonal code and last_of_run marking
//   the final face of a pixel. Each pixel gives 4 to 9 faces; the output
//   register moves one face per cycle while i_face_ready is high, with 4
//   faces for a pixel inside the image and more for the border pixels.
//   The first face of a pixel passes the stage register at acceptance,
//   then the queue, then the output register. A 4-entry queue lets the
//   front keep accepting while the receiver stalls; when it fills,
//   o_pixel_ready drops until faces drain.
//   Width and height are set through the write port (i_cfg_wr_en,
//   i_cfg_index, i_cfg_data) while idle; a write restarts the frame.
//   Reset sets width and height to 1 and the frame position to the origin.
//   The line store is not cleared: row 0 reads it but never uses the value.
// ----------------------------------------------------------------------------
`default_nettype none

`include "saddle_aware_span_interpolation_assert.svh"

module saddle_aware_span_interpolation #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_pixel_valid,
    output logic                             o_pixel_ready,
    input  logic [sasi_pkg::PIX_W-1:0]       i_pixel,
    input  logic                             i_cfg_wr_en,
    input  logic [sasi_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sasi_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                             o_face_valid,
    input  logic                             i_face_ready,
    output logic [sasi_pkg::GRID_W-1:0]      o_grid_row,
    output logic [sasi_pkg::GRID_W-1:0]      o_grid_col,
    output logic [sasi_pkg::PIX_W-1:0]       o_low_value,
    output logic [sasi_pkg::PIX_W-1:0]       o_high_value,
    output logic [1:0]                       o_diag_code,
    output logic                             o_last_of_run
);

    sasi_pkg::t_entry      push_entry;
    sasi_pkg::t_entry      head_entry;
    sasi_pkg::t_queue_stat queue_stat;
    logic                  push;
    logic                  pop;

    // accept and classify
    sasi_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pixel_valid (i_pixel_valid),
        .o_pixel_ready (o_pixel_ready),
        .i_pixel       (i_pixel),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_queue_stat  (queue_stat),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    // decoupling queue
    sasi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_stat  (queue_stat)
    );

    // face sequencer
    sasi_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (head_entry),
        .i_queue_stat  (queue_stat),
        .o_pop         (pop),
        .i_face_ready  (i_face_ready),
        .o_face_valid  (o_face_valid),
        .o_grid_row    (o_grid_row),
        .o_grid_col    (o_grid_col),
        .o_low_value   (o_low_value),
        .o_high_value  (o_high_value),
        .o_diag_code   (o_diag_code),
        .o_last_of_run (o_last_of_run)
    );

    // interval ends are ordered on every face
    `SASI_ASSERT_IMPL(a_interval_order, i_clk, i_rst_n, o_face_valid, o_low_value <= o_high_value)
    // a diagonal link only ever appears on a corner face
    `SASI_ASSERT_IMPL(a_diag_on_corner, i_clk, i_rst_n, o_face_valid && (o_diag_code != sasi_pkg::DIAG_NONE), !o_grid_row[0] && !o_grid_col[0])
    // faces of one pixel follow without gaps
    `SASI_ASSERT_NEXT(a_run_gapless, i_clk, i_rst_n, o_face_valid && i_face_ready && !o_last_of_run, o_face_valid)

endmodule

`default_nettype wire
